// ===== hw/rtl/fisr_pkg.sv =====
// Shared types, constants and rounding functions of the inverse square root pipeline.
package fisr_pkg;

  localparam int DATA_W = 64;
  localparam int SIG_W = 53;
  localparam int SIG32_W = 24;
  localparam int EXP_W = 14;
  localparam int MAG_W = 111;
  localparam int SUM_W = MAG_W + 1;
  localparam int RND_W = MAG_W + 2;
  localparam int LSB_W = 8;
  localparam int CNT_W = 7;
  localparam int NST = 27;
  localparam int LO_W = 27;
  localparam int HI_W = SIG_W - LO_W;
  localparam int PROD_W = 2 * SIG_W;

  typedef logic signed [EXP_W-1:0] exp_t;

  typedef enum logic {
    PREC_SINGLE = 1'b0,
    PREC_DOUBLE = 1'b1
  } prec_t;

  localparam logic [31:0] MAGIC32 = 32'h5F3759DF;
  localparam logic [63:0] MAGIC64 = 64'h5FE6EB50C7B537A9;
  localparam logic [31:0] QNAN32 = 32'h7FC00000;
  localparam logic [63:0] QNAN64 = 64'h7FF8000000000000;
  localparam logic [7:0] EXP_ALL32 = 8'hFF;
  localparam logic [10:0] EXP_ALL64 = 11'h7FF;

  localparam exp_t BIAS32 = exp_t'(127);
  localparam exp_t BIAS64 = exp_t'(1023);
  localparam exp_t EMIN32 = exp_t'(-126);
  localparam exp_t EMIN64 = exp_t'(-1022);
  localparam exp_t EMAX32 = exp_t'(127);
  localparam exp_t EMAX64 = exp_t'(1023);
  localparam exp_t EXP_ONE = exp_t'(1);
  localparam exp_t DEN_LIMIT = exp_t'(60);

  localparam logic [LSB_W-1:0] LSB32 = LSB_W'(MAG_W - SIG32_W);
  localparam logic [LSB_W-1:0] LSB64 = LSB_W'(MAG_W - SIG_W);
  localparam logic [LSB_W-1:0] LSB_FLUSH = LSB_W'(127);

  // Unpacked value: sig holds a leading one at its top bit once normalized, unless a flag is set.
  typedef struct packed {
    logic             nan;
    logic             inf;
    logic             zero;
    logic             sgn;
    exp_t             exp;
    logic [SIG_W-1:0] sig;
  } uf_t;

  // Exact value before rounding: mag holds a leading one at its top bit.
  typedef struct packed {
    logic             nan;
    logic             inf;
    logic             zero;
    logic             sgn;
    exp_t             exp;
    logic [MAG_W-1:0] mag;
    logic             stk;
  } rin_t;

  typedef struct packed {
    rin_t             r;
    logic [LSB_W-1:0] lsb;
  } rmid_t;

  typedef struct packed {
    logic nan;
    logic inf;
    logic zero;
    logic sgn;
    exp_t exp;
  } mhd_t;

  typedef struct packed {
    logic             nan;
    logic             inf;
    logic             sgn;
    logic             sub;
    exp_t             exp;
    logic [SIG_W-1:0] big;
    logic [SIG_W-1:0] small_sig;
    logic [EXP_W-1:0] exp_diff;
  } add1_t;

  typedef struct packed {
    logic             nan;
    logic             inf;
    logic             sgn;
    exp_t             exp;
    logic [SUM_W-1:0] sum;
  } add2_t;

  typedef struct packed {
    add2_t            s;
    logic [CNT_W-1:0] cnt;
  } add3_t;

  localparam uf_t THREE_HALVES = '{nan: 1'b0, inf: 1'b0, zero: 1'b0, sgn: 1'b0,
                                   exp: exp_t'(0), sig: 53'h18000000000000};

  function automatic logic [LSB_W-1:0] rnd_prep(input rin_t r, input prec_t m);
    exp_t             emin;
    exp_t             d;
    logic [LSB_W-1:0] lsb;
    emin = (m == PREC_DOUBLE) ? EMIN64 : EMIN32;
    lsb = (m == PREC_DOUBLE) ? LSB64 : LSB32;
    d = emin - r.exp;
    if (r.exp < emin) begin
      if (d > DEN_LIMIT) begin
        lsb = LSB_FLUSH;
      end else begin
        lsb = lsb + {2'b00, d[5:0]};
      end
    end
    return lsb;
  endfunction

  function automatic uf_t rnd_fin(input rin_t r, input logic [LSB_W-1:0] lsb, input prec_t m);
    logic [RND_W-1:0] mx;
    logic [RND_W-1:0] ulp;
    logic [RND_W-1:0] hulp;
    logic [RND_W-1:0] trunc;
    logic [RND_W-1:0] sum;
    logic             guard;
    logic             stk;
    logic             odd;
    logic             up;
    exp_t             emax;
    uf_t              u;
    mx = {2'b00, r.mag};
    ulp = RND_W'(1) << lsb;
    hulp = ulp >> 1;
    guard = |(mx & hulp);
    stk = (|(mx & (hulp - 1'b1))) | r.stk;
    odd = |(mx & ulp);
    up = guard & (stk | odd);
    trunc = mx & ~(ulp - 1'b1);
    sum = trunc + (up ? ulp : '0);
    emax = (m == PREC_DOUBLE) ? EMAX64 : EMAX32;
    u.nan = r.nan;
    u.inf = r.inf;
    u.zero = r.zero;
    u.sgn = r.sgn;
    u.exp = r.exp;
    u.sig = '0;
    if (!(r.nan || r.inf || r.zero)) begin
      if ((lsb > LSB_W'(MAG_W)) || (sum == '0)) begin
        u.zero = 1'b1;
      end else if (sum[MAG_W]) begin
        u.exp = r.exp + EXP_ONE;
        u.sig = sum[MAG_W -: SIG_W];
      end else begin
        u.sig = sum[MAG_W-1 -: SIG_W];
      end
      if (!u.zero && (u.exp > emax)) begin
        u.inf = 1'b1;
        u.sig = '0;
      end
    end
    return u;
  endfunction

endpackage

// ===== hw/rtl/fisr_mul.sv =====
// Pipelined floating-point multiplier with round to nearest even, five register stages.
module fisr_mul (
  input  logic            clk,
  input  logic            en,
  input  fisr_pkg::uf_t   a,
  input  fisr_pkg::uf_t   b,
  input  fisr_pkg::prec_t mode,
  output fisr_pkg::uf_t   p
);
  import fisr_pkg::*;

  logic [2*HI_W-1:0]      pp_hh_r;
  logic [HI_W+LO_W-1:0]   pp_hl_r;
  logic [HI_W+LO_W-1:0]   pp_lh_r;
  logic [2*LO_W-1:0]      pp_ll_r;
  mhd_t                   hd1_r;
  mhd_t                   hd2_r;
  logic [PROD_W-1:0]      prod2_r;
  logic [PROD_W-1:0]      prod_nxt;
  rin_t                   rin3_r;
  rin_t                   rin_nxt;
  rmid_t                  rm4_r;
  uf_t                    p_r;
  prec_t                  mode_r [0:3];
  mhd_t                   hd_nxt;

  always_comb begin
    hd_nxt.nan = a.nan | b.nan | (a.inf & b.zero) | (a.zero & b.inf);
    hd_nxt.inf = !hd_nxt.nan & (a.inf | b.inf);
    hd_nxt.zero = !hd_nxt.nan & !hd_nxt.inf & (a.zero | b.zero);
    hd_nxt.sgn = a.sgn ^ b.sgn;
    hd_nxt.exp = a.exp + b.exp;
  end

  assign prod_nxt = {pp_hh_r, 54'd0} + PROD_W'({pp_hl_r, 27'd0})
                  + PROD_W'({pp_lh_r, 27'd0}) + PROD_W'(pp_ll_r);

  always_comb begin
    rin_nxt.nan = hd2_r.nan;
    rin_nxt.inf = hd2_r.inf;
    rin_nxt.zero = hd2_r.zero;
    rin_nxt.sgn = hd2_r.sgn;
    rin_nxt.stk = 1'b0;
    if (prod2_r[PROD_W-1]) begin
      rin_nxt.exp = hd2_r.exp + EXP_ONE;
      rin_nxt.mag = {prod2_r, 5'd0};
    end else begin
      rin_nxt.exp = hd2_r.exp;
      rin_nxt.mag = {prod2_r[PROD_W-2:0], 6'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh_r <= a.sig[SIG_W-1:LO_W] * b.sig[SIG_W-1:LO_W];
      pp_hl_r <= a.sig[SIG_W-1:LO_W] * b.sig[LO_W-1:0];
      pp_lh_r <= a.sig[LO_W-1:0] * b.sig[SIG_W-1:LO_W];
      pp_ll_r <= a.sig[LO_W-1:0] * b.sig[LO_W-1:0];
      hd1_r <= hd_nxt;
      mode_r[0] <= mode;
      prod2_r <= prod_nxt;
      hd2_r <= hd1_r;
      mode_r[1] <= mode_r[0];
      rin3_r <= rin_nxt;
      mode_r[2] <= mode_r[1];
      rm4_r.r <= rin3_r;
      rm4_r.lsb <= rnd_prep(rin3_r, mode_r[2]);
      mode_r[3] <= mode_r[2];
      p_r <= rnd_fin(rm4_r.r, rm4_r.lsb, mode_r[3]);
    end
  end

  assign p = p_r;

endmodule

// ===== hw/rtl/fast_inverse_square_root.sv =====
// Top level of the pipelined magic-constant inverse square root unit.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in      | in        | in_tvalid/in_tready | in_tdata[63:0]  = operand_bits
//  out     | out       | out_tvalid/out_tready | out_tdata[63:0] = result_bits
//  cfg     | in        | cfg_wr_en           | cfg_wr_data[0]  = precision_mode
//
// One item is accepted per cycle while in_tready is high.
// Between acceptance and out_tvalid lie six front-end stages, three five-stage multipliers,
// a six-stage subtract-and-round path and the output register.
// Reset clears the valid bits, out_valid_r and precision_mode (binary32); out_data_r is not reset.
// A stalled output freezes the pipeline only while its last stage holds an item.
module fast_inverse_square_root (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,   // precision_mode
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [fisr_pkg::DATA_W-1:0] in_tdata,      // operand_bits
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [fisr_pkg::DATA_W-1:0] out_tdata      // result_bits
);
  import fisr_pkg::*;

  prec_t              prec_r;
  logic [NST-1:0]     v_r;
  prec_t              md_r [0:NST-1];
  logic [DATA_W-1:0]  x0_r;
  uf_t                xu1_r;
  uf_t                yu1_r;
  uf_t                xu2_r;
  uf_t                yu2_r;
  logic [5:0]         xc2_r;
  logic [5:0]         yc2_r;
  rin_t               hx3_r;
  rmid_t              hm4_r;
  uf_t                h5_r;
  uf_t                yd_r [3:21];
  uf_t                p1;
  uf_t                p2;
  uf_t                p2_neg;
  add1_t              a1_r;
  add2_t              a2_r;
  add3_t              a3_r;
  rin_t               a4_r;
  rmid_t              rm20_r;
  uf_t                t21_r;
  uf_t                r26;
  logic               out_valid_r;
  logic [DATA_W-1:0]  out_data_r;
  prec_t              out_mode_r;
  logic               en;
  logic [DATA_W-1:0]  guess_nxt;
  uf_t                xn_nxt;
  rin_t               hx_nxt;

  function automatic uf_t unpack_raw(input logic [DATA_W-1:0] b, input prec_t m);
    logic [10:0] e;
    logic [51:0] f;
    logic        all1;
    uf_t         u;
    if (m == PREC_DOUBLE) begin
      e = b[62:52];
      f = b[51:0];
      all1 = (e == EXP_ALL64);
      u.sgn = b[63];
    end else begin
      e = {3'b000, b[30:23]};
      f = {b[22:0], 29'd0};
      all1 = (e == {3'b000, EXP_ALL32});
      u.sgn = b[31];
    end
    u.nan = all1 && (f != '0);
    u.inf = all1 && (f == '0);
    u.zero = (e == '0) && (f == '0);
    u.sig = {(e != '0), f};
    u.exp = $signed({3'b000, (e == '0) ? 11'd1 : e})
          - ((m == PREC_DOUBLE) ? BIAS64 : BIAS32);
    return u;
  endfunction

  function automatic logic [5:0] lzc53(input logic [SIG_W-1:0] s);
    logic [5:0] c;
    c = '0;
    for (int i = 0; i < SIG_W; i++) begin
      if (s[i]) begin
        c = 6'(SIG_W - 1 - i);
      end
    end
    return c;
  endfunction

  function automatic logic [CNT_W-1:0] lzc112(input logic [SUM_W-1:0] s);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (s[i]) begin
        c = CNT_W'(SUM_W - 1 - i);
      end
    end
    return c;
  endfunction

  function automatic uf_t norm_uf(input uf_t u, input logic [5:0] c);
    uf_t o;
    o = u;
    o.sig = u.sig << c;
    o.exp = u.exp - $signed({8'd0, c});
    return o;
  endfunction

  function automatic add1_t add_swap(input uf_t a, input uf_t b);
    logic  b_big;
    add1_t r;
    b_big = !b.zero && ((b.exp > a.exp) || ((b.exp == a.exp) && (b.sig > a.sig)));
    r.nan = a.nan | b.nan | (a.inf & b.inf & (a.sgn != b.sgn));
    r.inf = !r.nan & (a.inf | b.inf);
    r.sub = a.sgn ^ b.sgn;
    if (b_big) begin
      r.sgn = b.sgn;
      r.exp = b.exp;
      r.big = b.sig;
      r.small_sig = a.zero ? '0 : a.sig;
      r.exp_diff = EXP_W'(b.exp - a.exp);
    end else begin
      r.sgn = a.sgn;
      r.exp = a.exp;
      r.big = a.sig;
      r.small_sig = b.zero ? '0 : b.sig;
      r.exp_diff = EXP_W'(a.exp - b.exp);
    end
    if (a.inf) begin
      r.sgn = a.sgn;
    end else if (b.inf) begin
      r.sgn = b.sgn;
    end
    return r;
  endfunction

  function automatic add2_t add_align(input add1_t s);
    logic [MAG_W-1:0] xb;
    logic [MAG_W-1:0] xs;
    logic [MAG_W-1:0] sh;
    logic             jam;
    add2_t            r;
    xb = {s.big, 58'd0};
    xs = {s.small_sig, 58'd0};
    if (s.exp_diff >= EXP_W'(MAG_W)) begin
      sh = '0;
      jam = |s.small_sig;
    end else begin
      sh = xs >> s.exp_diff[CNT_W-1:0];
      jam = |(xs & ((MAG_W'(1) << s.exp_diff[CNT_W-1:0]) - 1'b1));
    end
    sh = sh | MAG_W'(jam);
    r.nan = s.nan;
    r.inf = s.inf;
    r.sgn = s.sgn;
    r.exp = s.exp;
    r.sum = s.sub ? ({1'b0, xb} - {1'b0, sh}) : ({1'b0, xb} + {1'b0, sh});
    return r;
  endfunction

  function automatic rin_t add_norm(input add3_t s);
    logic [SUM_W-1:0] nv;
    rin_t             r;
    nv = s.s.sum << s.cnt;
    r.nan = s.s.nan;
    r.inf = s.s.inf;
    r.zero = !s.s.nan && !s.s.inf && (s.s.sum == '0);
    r.sgn = r.zero ? 1'b0 : s.s.sgn;
    r.exp = s.s.exp + EXP_ONE - $signed({7'd0, s.cnt});
    r.mag = nv[SUM_W-1:1];
    r.stk = nv[0];
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pack(input uf_t u, input prec_t m);
    exp_t             emin;
    exp_t             d;
    exp_t             bf;
    logic [10:0]      be;
    logic [SIG_W-1:0] sh;
    logic [DATA_W-1:0] o;
    emin = (m == PREC_DOUBLE) ? EMIN64 : EMIN32;
    d = emin - u.exp;
    bf = u.exp + ((m == PREC_DOUBLE) ? BIAS64 : BIAS32);
    if (u.exp < emin) begin
      sh = (d > exp_t'(SIG_W)) ? '0 : (u.sig >> d[5:0]);
      be = '0;
    end else begin
      sh = u.sig;
      be = bf[10:0];
    end
    if (m == PREC_DOUBLE) begin
      if (u.nan) begin
        o = QNAN64;
      end else if (u.inf) begin
        o = {u.sgn, EXP_ALL64, 52'd0};
      end else if (u.zero) begin
        o = {u.sgn, 63'd0};
      end else begin
        o = {u.sgn, be, sh[51:0]};
      end
    end else begin
      if (u.nan) begin
        o = {32'd0, QNAN32};
      end else if (u.inf) begin
        o = {32'd0, u.sgn, EXP_ALL32, 23'd0};
      end else if (u.zero) begin
        o = {32'd0, u.sgn, 31'd0};
      end else begin
        o = {32'd0, u.sgn, be[7:0], sh[51:29]};
      end
    end
    return o;
  endfunction

  assign en = !(out_valid_r && !out_tready && v_r[NST-1]);
  assign in_tready = en;
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  always_comb begin
    if (md_r[0] == PREC_DOUBLE) begin
      guess_nxt = MAGIC64 - {x0_r[63], x0_r[63:1]};
    end else begin
      guess_nxt = {32'd0, MAGIC32 - {x0_r[31], x0_r[31:1]}};
    end
  end

  always_comb begin
    xn_nxt = norm_uf(xu2_r, xc2_r);
    hx_nxt.nan = xn_nxt.nan;
    hx_nxt.inf = xn_nxt.inf;
    hx_nxt.zero = xn_nxt.zero;
    hx_nxt.sgn = xn_nxt.sgn;
    hx_nxt.exp = xn_nxt.exp - EXP_ONE;
    hx_nxt.mag = {xn_nxt.sig, 58'd0};
    hx_nxt.stk = 1'b0;
  end

  always_comb begin
    p2_neg = p2;
    p2_neg.sgn = !p2.sgn;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prec_r <= PREC_SINGLE;
    end else if (cfg_wr_en) begin
      prec_r <= prec_t'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      md_r[0] <= prec_r;
      for (int i = 1; i < NST; i++) begin
        md_r[i] <= md_r[i-1];
      end
      x0_r <= in_tdata;
      xu1_r <= unpack_raw(x0_r, md_r[0]);
      yu1_r <= unpack_raw(guess_nxt, md_r[0]);
      xu2_r <= xu1_r;
      yu2_r <= yu1_r;
      xc2_r <= lzc53(xu1_r.sig);
      yc2_r <= lzc53(yu1_r.sig);
      hx3_r <= hx_nxt;
      yd_r[3] <= norm_uf(yu2_r, yc2_r);
      for (int i = 4; i <= 21; i++) begin
        yd_r[i] <= yd_r[i-1];
      end
      hm4_r.r <= hx3_r;
      hm4_r.lsb <= rnd_prep(hx3_r, md_r[3]);
      h5_r <= rnd_fin(hm4_r.r, hm4_r.lsb, md_r[4]);
      a1_r <= add_swap(THREE_HALVES, p2_neg);
      a2_r <= add_align(a1_r);
      a3_r.s <= a2_r;
      a3_r.cnt <= lzc112(a2_r.sum);
      a4_r <= add_norm(a3_r);
      rm20_r.r <= a4_r;
      rm20_r.lsb <= rnd_prep(a4_r, md_r[19]);
      t21_r <= rnd_fin(rm20_r.r, rm20_r.lsb, md_r[20]);
    end
  end

  fisr_mul u_mul_p1 (
    .clk  (clk),
    .en   (en),
    .a    (h5_r),
    .b    (yd_r[5]),
    .mode (md_r[5]),
    .p    (p1)
  );

  fisr_mul u_mul_p2 (
    .clk  (clk),
    .en   (en),
    .a    (p1),
    .b    (yd_r[10]),
    .mode (md_r[10]),
    .p    (p2)
  );

  fisr_mul u_mul_r (
    .clk  (clk),
    .en   (en),
    .a    (yd_r[21]),
    .b    (t21_r),
    .mode (md_r[21]),
    .p    (r26)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= v_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_data_r <= pack(r26, md_r[NST-1]);
      out_mode_r <= md_r[NST-1];
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input not ready although the output register is empty");

  a_freeze_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && v_r[NST-1]) |=> $stable(v_r))
    else $error("pipeline moved while its last item was blocked");

  a_single_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_mode_r == PREC_SINGLE)) |-> (out_data_r[63:32] == '0))
    else $error("binary32 result has nonzero upper half");

  a_double_nan_canon: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_mode_r == PREC_DOUBLE) && (out_data_r[62:52] == EXP_ALL64) &&
     (out_data_r[51:0] != '0)) |-> (out_data_r == QNAN64))
    else $error("binary64 NaN result is not canonical");

endmodule
